// ----- hw/rtl/svq_pkg.sv -----
// Shared constants, control structs and the size function of the split virtqueue manager.
`default_nettype none

package svq_pkg;

    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int MAX_SIZE        = 256;
    localparam int SIZE_W          = 9;

    // operation codes carried in func
    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_GET  = 3'd1;
    localparam logic [2:0] FN_FREE = 3'd2;
    localparam logic [2:0] FN_DONE = 3'd3;
    localparam logic [2:0] FN_READ = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic data_we;
        logic link_we;
        logic init;
    } desc_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } used_ctl_t;

    // Clamp to the limit, take zero as one, round down to a power of two.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] c;
        logic [SIZE_W-1:0] p;
        c = (v > lim) ? lim : v;
        if (c == '0)
        begin
            c = SIZE_W'(1);
        end
        p = SIZE_W'(1);
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (c[i])
            begin
                p = SIZE_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/svq_desc_store.sv -----
// Descriptor table: address, length, write flag and next-link memories.
`default_nettype none

module svq_desc_store #(
    parameter int DEPTH = svq_pkg::DEF_QUEUE_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire svq_pkg::desc_ctl_t ctl,
    input  wire logic [IDX_W-1:0] rd_addr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [63:0]      wr_buf_addr,
    input  wire logic [31:0]      wr_buf_len,
    input  wire logic             wr_writable,
    input  wire logic [IDX_W-1:0] link_addr,
    input  wire logic [IDX_W-1:0] link_data,
    input  wire logic [IDX_W-1:0] last_idx,
    output logic [63:0]           rd_buf_addr,
    output logic [31:0]           rd_buf_len,
    output logic                  rd_writable,
    output logic [IDX_W-1:0]      rd_link
);

    logic [63:0]      addr_mem [DEPTH];
    logic [31:0]      len_mem  [DEPTH];
    logic             wrf_mem  [DEPTH];
    logic [IDX_W-1:0] link_mem [DEPTH];

    logic [DEPTH-1:0] link_valid_reg;
    logic [63:0]      rd_addr_reg;
    logic [31:0]      rd_len_reg;
    logic             rd_wrf_reg;
    logic [IDX_W-1:0] rd_link_reg;
    logic             rd_link_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] link_rst_val;

    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
        begin
            addr_mem[wr_addr] <= wr_buf_addr;
            len_mem[wr_addr]  <= wr_buf_len;
            wrf_mem[wr_addr]  <= wr_writable;
        end
        if (ctl.rd_en)
        begin
            rd_addr_reg <= addr_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
            rd_wrf_reg  <= wrf_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
        if (ctl.rd_en)
        begin
            rd_link_reg       <= link_mem[rd_addr];
            rd_link_valid_reg <= link_valid_reg[rd_addr];
            rd_idx_reg        <= rd_addr;
        end
    end

    // An unwritten link reads as its initial chain value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
        end
        else if (ctl.init)
        begin
            link_valid_reg <= '0;
        end
        else if (ctl.link_we)
        begin
            link_valid_reg[link_addr] <= 1'b1;
        end
    end

    assign link_rst_val = (rd_idx_reg == last_idx) ? '0 : rd_idx_reg + IDX_W'(1);

    assign rd_buf_addr = rd_addr_reg;
    assign rd_buf_len  = rd_len_reg;
    assign rd_writable = rd_wrf_reg;
    assign rd_link     = rd_link_valid_reg ? rd_link_reg : link_rst_val;

endmodule

`default_nettype wire

// ----- hw/rtl/svq_used_ring.sv -----
// Used ring: id and length memories written by device completion, read by get.
`default_nettype none

module svq_used_ring #(
    parameter int DEPTH = svq_pkg::DEF_QUEUE_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire svq_pkg::used_ctl_t ctl,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [31:0]      wr_id,
    input  wire logic [31:0]      wr_len,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic [31:0]           rd_id,
    output logic [31:0]           rd_len
);

    logic [31:0] id_mem  [DEPTH];
    logic [31:0] len_mem [DEPTH];
    logic [31:0] rd_id_reg;
    logic [31:0] rd_len_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            id_mem[wr_addr]  <= wr_id;
            len_mem[wr_addr] <= wr_len;
        end
        if (ctl.rd_en)
        begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_len_reg <= len_mem[rd_addr];
        end
    end

    assign rd_id  = rd_id_reg;
    assign rd_len = rd_len_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/split_virtqueue_ring_manager.sv -----
// Top level of the split virtqueue driver-side ring manager.
//
//  channel  | direction | handshake             | words carried
//  ---------+-----------+-----------------------+--------------------------------------------
//  cfg      | in        | cfg_valid / cfg_ready | cfg_data: queue_size
//  in       | in        | in_valid / in_ready   | func, buf_addr, buf_len, buf_writable,
//           |           |                       | desc_index, done_id, done_len
//  out      | out       | out_valid / out_ready | status, index_out, avail_index_out, len_out,
//           |           |                       | addr_out, writable_out, next_out, free_count_out
//
//  The accept edge issues the memory reads (free-list head link, used-ring slot, requested descriptor);
//  the completion edge, once the output register is free or being read, updates state and loads the result.
//  One operation is in flight at a time, set by the head read/rewrite through the link memory.
//  Reset and a queue_size write rebuild the free list at once through per-entry link valid bits;
//  there is no clearing pass. A stalled result holds in the output register while the next word
//  is accepted; that word then waits in the input stage until the output frees up.
`default_nettype none

module split_virtqueue_ring_manager #(
    parameter int QUEUE_DEPTH = svq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [63:0] buf_addr,
    input  wire logic [31:0] buf_len,
    input  wire logic        buf_writable,
    input  wire logic [7:0]  desc_index,
    input  wire logic [31:0] done_id,
    input  wire logic [31:0] done_len,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       index_out,
    output logic [15:0]      avail_index_out,
    output logic [31:0]      len_out,
    output logic [63:0]      addr_out,
    output logic             writable_out,
    output logic [7:0]       next_out,
    output logic [8:0]       free_count_out
);

    localparam int DEPTH = (QUEUE_DEPTH < svq_pkg::MAX_SIZE) ? QUEUE_DEPTH : svq_pkg::MAX_SIZE;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [8:0] SIZE_LIM = 9'(DEPTH);
    localparam logic [8:0] RST_SIZE = svq_pkg::eff_size(9'd256, SIZE_LIM);

    // queue state
    logic [8:0]       qsize_reg;
    logic [IDX_W-1:0] mask_reg;
    logic [IDX_W-1:0] head_reg,   head_next;
    logic [8:0]       fcount_reg, fcount_next;
    logic [15:0]      avail_reg,  avail_next;
    logic [15:0]      used_reg,   used_next;
    logic [15:0]      cons_reg,   cons_next;
    logic [8:0]       cfg_size;

    // input stage
    logic             s1_valid_reg;
    logic [2:0]       s1_func_reg;
    logic [63:0]      s1_buf_addr_reg;
    logic [31:0]      s1_buf_len_reg;
    logic             s1_wr_reg;
    logic [7:0]       s1_di_reg;
    logic [31:0]      s1_done_id_reg;
    logic [31:0]      s1_done_len_reg;

    // result register
    logic             out_valid_reg;
    logic [1:0]       status_reg,   status_next;
    logic [7:0]       index_reg,    index_next;
    logic [31:0]      len_reg,      len_next;
    logic [63:0]      addr_reg,     addr_next;
    logic             wrf_reg,      wrf_next;
    logic [7:0]       nxt_reg,      nxt_next;

    logic             accept;
    logic             cfg_we;
    logic             fire;
    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] s1_di_idx;

    svq_pkg::desc_ctl_t desc_ctl;
    svq_pkg::used_ctl_t used_ctl;
    logic [IDX_W-1:0] desc_rd_addr;
    logic [IDX_W-1:0] link_addr;
    logic [IDX_W-1:0] link_data;
    logic             data_we;
    logic             link_we;
    logic             used_we;
    logic [63:0]      rd_buf_addr;
    logic [31:0]      rd_buf_len;
    logic             rd_writable;
    logic [IDX_W-1:0] rd_link;
    logic [31:0]      rd_used_id;
    logic [31:0]      rd_used_len;

    // Config wins over a new word; both are only taken with no word in flight.
    assign cfg_ready = !s1_valid_reg;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_ready  = !s1_valid_reg && !cfg_valid;
    assign accept    = in_valid && in_ready;
    assign fire      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign cfg_size  = svq_pkg::eff_size(cfg_data, SIZE_LIM);

    assign head_idx  = head_reg & mask_reg;
    assign s1_di_idx = s1_di_reg[IDX_W-1:0];

    // Issue reads on accept: add needs the head link, read needs the requested entry.
    assign desc_rd_addr = (func == svq_pkg::FN_ADD) ? head_idx : desc_index[IDX_W-1:0];

    assign desc_ctl.rd_en   = accept;
    assign desc_ctl.data_we = data_we;
    assign desc_ctl.link_we = link_we;
    assign desc_ctl.init    = cfg_we;
    assign used_ctl.rd_en   = accept;
    assign used_ctl.wr_en   = used_we;

    svq_desc_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_desc (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (desc_ctl),
        .rd_addr     (desc_rd_addr),
        .wr_addr     (head_idx),
        .wr_buf_addr (s1_buf_addr_reg),
        .wr_buf_len  (s1_buf_len_reg),
        .wr_writable (s1_wr_reg),
        .link_addr   (link_addr),
        .link_data   (link_data),
        .last_idx    (mask_reg),
        .rd_buf_addr (rd_buf_addr),
        .rd_buf_len  (rd_buf_len),
        .rd_writable (rd_writable),
        .rd_link     (rd_link)
    );

    svq_used_ring #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_used (
        .clk     (clk),
        .ctl     (used_ctl),
        .wr_addr (used_reg[IDX_W-1:0] & mask_reg),
        .wr_id   (s1_done_id_reg),
        .wr_len  (s1_done_len_reg),
        .rd_addr (cons_reg[IDX_W-1:0] & mask_reg),
        .rd_id   (rd_used_id),
        .rd_len  (rd_used_len)
    );

    // Resolve the word held in the input stage against the registered read data.
    always_comb
    begin
        head_next   = head_reg;
        fcount_next = fcount_reg;
        avail_next  = avail_reg;
        used_next   = used_reg;
        cons_next   = cons_reg;
        status_next = svq_pkg::ST_OK;
        index_next  = '0;
        len_next    = '0;
        addr_next   = '0;
        wrf_next    = 1'b0;
        nxt_next    = '0;
        data_we     = 1'b0;
        link_we     = 1'b0;
        used_we     = 1'b0;
        link_addr   = head_idx;
        link_data   = '0;
        unique case (s1_func_reg)
            svq_pkg::FN_ADD:
            begin
                if (fcount_reg == '0)
                begin
                    status_next = svq_pkg::ST_FULL;
                end
                else
                begin
                    // pop the head and chain it off
                    head_next   = rd_link;
                    fcount_next = fcount_reg - 9'd1;
                    avail_next  = avail_reg + 16'd1;
                    index_next  = 8'(head_idx);
                    data_we     = fire;
                    link_we     = fire;
                end
            end
            svq_pkg::FN_GET:
            begin
                if (cons_reg == used_reg)
                begin
                    status_next = svq_pkg::ST_FULL;
                end
                else
                begin
                    cons_next = cons_reg + 16'd1;
                    if (rd_used_id >= {23'd0, qsize_reg})
                    begin
                        status_next = svq_pkg::ST_BAD;
                    end
                    else
                    begin
                        index_next = rd_used_id[7:0];
                        len_next   = rd_used_len;
                    end
                end
            end
            svq_pkg::FN_FREE:
            begin
                if ({1'b0, s1_di_reg} >= qsize_reg || fcount_reg >= qsize_reg)
                begin
                    status_next = svq_pkg::ST_BAD;
                end
                else
                begin
                    // push onto the free list
                    link_addr   = s1_di_idx;
                    link_data   = head_reg;
                    link_we     = fire;
                    head_next   = s1_di_idx;
                    fcount_next = fcount_reg + 9'd1;
                end
            end
            svq_pkg::FN_DONE:
            begin
                if (16'(used_reg - cons_reg) >= {7'd0, qsize_reg})
                begin
                    status_next = svq_pkg::ST_FULL;
                end
                else
                begin
                    used_we   = fire;
                    used_next = used_reg + 16'd1;
                end
            end
            svq_pkg::FN_READ:
            begin
                if ({1'b0, s1_di_reg} >= qsize_reg)
                begin
                    status_next = svq_pkg::ST_BAD;
                end
                else
                begin
                    len_next  = rd_buf_len;
                    addr_next = rd_buf_addr;
                    wrf_next  = rd_writable;
                    nxt_next  = 8'(rd_link);
                end
            end
            default:
            begin
                status_next = svq_pkg::ST_BAD;
            end
        endcase
    end

    // queue state: rebuild on config, advance on completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg  <= RST_SIZE;
            mask_reg   <= IDX_W'(RST_SIZE - 9'd1);
            head_reg   <= '0;
            fcount_reg <= RST_SIZE;
            avail_reg  <= '0;
            used_reg   <= '0;
            cons_reg   <= '0;
        end
        else if (cfg_we)
        begin
            qsize_reg  <= cfg_size;
            mask_reg   <= IDX_W'(cfg_size - 9'd1);
            head_reg   <= '0;
            fcount_reg <= cfg_size;
            avail_reg  <= '0;
            used_reg   <= '0;
            cons_reg   <= '0;
        end
        else if (fire)
        begin
            head_reg   <= head_next;
            fcount_reg <= fcount_next;
            avail_reg  <= avail_next;
            used_reg   <= used_next;
            cons_reg   <= cons_next;
        end
    end

    // input stage: hold the word until its result can be loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg     <= func;
            s1_buf_addr_reg <= buf_addr;
            s1_buf_len_reg  <= buf_len;
            s1_wr_reg       <= buf_writable;
            s1_di_reg       <= desc_index;
            s1_done_id_reg  <= done_id;
            s1_done_len_reg <= done_len;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            wrf_reg    <= wrf_next;
            nxt_reg    <= nxt_next;
        end
    end

    // Counters in the result are the state after the operation, captured in their own registers
    // at the completion edge, since a queue_size write can change the state registers before the result is taken.
    logic [15:0] avail_out_reg;
    logic [8:0]  fcount_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            avail_out_reg  <= avail_next;
            fcount_out_reg <= fcount_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign index_out       = index_reg;
    assign avail_index_out = avail_out_reg;
    assign len_out         = len_reg;
    assign addr_out        = addr_reg;
    assign writable_out    = wrf_reg;
    assign next_out        = nxt_reg;
    assign free_count_out  = fcount_out_reg;

    // one word in flight: an accept closes the input until completion
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while a word was in flight");

    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= qsize_reg)
        else $error("free count exceeds queue size");

    a_used_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        16'(used_reg - cons_reg) <= {7'd0, qsize_reg})
        else $error("used ring holds more elements than the queue size");

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("pending word dropped while the result was stalled");

    a_state_frozen_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=>
            ($stable(head_reg) && $stable(fcount_reg) && $stable(cons_reg)))
        else $error("queue state changed while the result was stalled");

endmodule

`default_nettype wire
